@@ src/deapq_pkg.sv @@
`timescale 1ns / 1ps

package deapq_pkg;

	// Request kinds.
	localparam logic [1:0] KIND_ENQ  = 2'd0;
	localparam logic [1:0] KIND_PEEK = 2'd1;
	localparam logic [1:0] KIND_DEQ  = 2'd2;

	// Selection modes.
	localparam logic [1:0] MODE_HIGH   = 2'd0;
	localparam logic [1:0] MODE_LOW    = 2'd1;
	localparam logic [1:0] MODE_OLDEST = 2'd2;
	localparam logic [1:0] MODE_NEWEST = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	localparam int OCC_W = 5;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         mode;
		logic [31:0]        item_tag;
		logic signed [31:0] priority_req;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [31:0]        out_item;
		logic signed [31:0] out_priority;
		logic [31:0]        out_order;
		logic [OCC_W-1:0]   occupancy;
	} rsp_t;

endpackage

@@ src/deapq_ram.sv @@
`timescale 1ns / 1ps

module deapq_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/deapq_cmp.sv @@
`timescale 1ns / 1ps

module deapq_cmp import deapq_pkg::*; (
	input  logic [1:0]         mode,
	input  logic signed [31:0] a_prio,
	input  logic [31:0]        a_order,
	input  logic signed [31:0] b_prio,
	input  logic [31:0]        b_order,
	output logic               better
);

	logic older;
	logic newer;
	logic prio_gt;
	logic prio_lt;

	// Candidate a beats the current best b; equal priorities go to the older entry.
	always_comb begin
		older   = a_order < b_order;
		newer   = a_order > b_order;
		prio_gt = a_prio > b_prio;
		prio_lt = a_prio < b_prio;
		unique case (mode)
			MODE_HIGH:   better = prio_gt || (!prio_lt && older);
			MODE_LOW:    better = prio_lt || (!prio_gt && older);
			MODE_OLDEST: better = older;
			MODE_NEWEST: better = newer;
			default:     better = 1'b0;
		endcase
	end

endmodule

@@ src/double_ended_age_priority_queue.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_valid, req_stall  req_t: kind, mode, item_tag, priority_req
// rsp       out        rsp_valid, rsp_stall  rsp_t: status, out_item, out_priority,
//                                            out_order, occupancy
//
// A peek or dequeue on a non-empty store walks the whole entry memory: one shared
// comparator takes one slot per cycle in S_SCAN, S_DRAIN waits for the last registered
// read, and S_FIN updates state and loads the result.
// An enqueue walks the valid bits until the lowest free slot, writes the entry there and ends in S_FIN.
// Refused or empty requests and the undefined kind skip the walk and go straight to S_FIN.
// Reset (arst_n low) clears all valid bits, the occupancy and the order counter at once;
// no clearing pass is needed. req_stall is high while a transaction is being worked on.
// A finished result sits in the output register until taken, while the next request
// is already accepted; its final update waits only if that register is still full.

module double_ended_age_priority_queue import deapq_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int TAG_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int TW = (TAG_BITS < 32) ? TAG_BITS : 32;
	localparam int RW = TW + 64;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIN
	} state_t;

	state_t                state_q;
	logic [CAPACITY-1:0]   valid_q;
	logic [CW-1:0]         count_q;
	logic [31:0]           next_order_q;
	logic                  out_vld_q;
	logic [IW-1:0]         idx_q;
	logic                  scan_s1;
	logic                  cand_vld_s1;
	logic [IW-1:0]         cand_idx_s1;
	logic                  best_vld_q;
	logic [IW-1:0]         best_idx_q;

	// Payload registers.
	req_t                  req_q;
	logic [1:0]            status_q;
	logic [TW-1:0]         best_tag_q;
	logic signed [31:0]    best_prio_q;
	logic [31:0]           best_order_q;
	rsp_t                  rsp_q;

	logic                  is_enq;
	logic                  is_deq;
	logic                  idx_last;
	logic                  slot_free;
	logic                  fin_go;
	logic                  take;
	logic                  ram_we;
	logic [RW-1:0]         ram_wdata;
	logic [RW-1:0]         ram_rdata;
	logic [TW-1:0]         rd_tag;
	logic signed [31:0]    rd_prio;
	logic [31:0]           rd_order;
	logic                  cand_better;
	logic                  best_upd;
	logic [CW-1:0]         occ_next;

	assign is_enq    = (req_q.kind == KIND_ENQ);
	assign is_deq    = (req_q.kind == KIND_DEQ);
	assign idx_last  = (idx_q == IW'(CAPACITY - 1));
	assign slot_free = !valid_q[idx_q];
	assign fin_go    = !out_vld_q || !rsp_stall;
	assign take      = (state_q == S_IDLE) && req_valid;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_vld_q;
	assign rsp       = rsp_q;

	// The enqueue writes the first free slot that the walk reaches.
	assign ram_we    = (state_q == S_SCAN) && is_enq && slot_free;
	assign ram_wdata = {req_q.item_tag[TW-1:0], req_q.priority_req, next_order_q};

	deapq_ram #(
		.WIDTH(RW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign rd_tag   = ram_rdata[RW-1:64];
	assign rd_prio  = ram_rdata[63:32];
	assign rd_order = ram_rdata[31:0];

	deapq_cmp u_cmp (
		.mode   (req_q.mode),
		.a_prio (rd_prio),
		.a_order(rd_order),
		.b_prio (best_prio_q),
		.b_order(best_order_q),
		.better (cand_better)
	);

	// The first valid slot seen always becomes the best; later ones must beat it.
	assign best_upd = scan_s1 && cand_vld_s1 && (!best_vld_q || cand_better);

	assign occ_next = (is_deq && status_q == ST_OK) ? count_q - CW'(1) : count_q;

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			count_q      <= '0;
			next_order_q <= '0;
			out_vld_q    <= 1'b0;
			idx_q        <= '0;
			scan_s1      <= 1'b0;
			cand_vld_s1  <= 1'b0;
			cand_idx_s1  <= '0;
			best_vld_q   <= 1'b0;
			best_idx_q   <= '0;
		end else begin
			// A new result loads the output register; otherwise a taken one leaves it.
			if (state_q == S_FIN && fin_go) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
			scan_s1     <= (state_q == S_SCAN) && !is_enq;
			cand_vld_s1 <= valid_q[idx_q];
			cand_idx_s1 <= idx_q;
			if (best_upd) begin
				best_vld_q <= 1'b1;
				best_idx_q <= cand_idx_s1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						idx_q      <= '0;
						best_vld_q <= 1'b0;
						priority if (req.kind == KIND_ENQ) begin
							if (count_q == CW'(CAPACITY) || next_order_q == '1) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (req.kind == KIND_PEEK || req.kind == KIND_DEQ) begin
							state_q <= (count_q == '0) ? S_FIN : S_SCAN;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					if (is_enq) begin
						if (slot_free) begin
							valid_q[idx_q] <= 1'b1;
							count_q        <= count_q + CW'(1);
							next_order_q   <= next_order_q + 32'd1;
							state_q        <= S_FIN;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end else if (idx_last) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (is_deq && status_q == ST_OK) begin
							valid_q[best_idx_q] <= 1'b0;
							count_q             <= count_q - CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request, running best entry and result payload.
	always_ff @(posedge clk) begin
		if (take) begin
			req_q        <= req;
			best_tag_q   <= '0;
			best_prio_q  <= '0;
			best_order_q <= '0;
			priority if (req.kind == KIND_ENQ) begin
				if (count_q == CW'(CAPACITY)) begin
					status_q <= ST_FULL;
				end else if (next_order_q == '1) begin
					status_q <= ST_EXHAUSTED;
				end else begin
					status_q <= ST_OK;
				end
			end else if (req.kind == KIND_PEEK || req.kind == KIND_DEQ) begin
				status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
			end else begin
				status_q <= ST_OK;
			end
		end
		if (best_upd) begin
			best_tag_q   <= rd_tag;
			best_prio_q  <= rd_prio;
			best_order_q <= rd_order;
		end
		if (ram_we) begin
			best_order_q <= next_order_q;
		end
		if (state_q == S_FIN && fin_go) begin
			rsp_q.status       <= status_q;
			rsp_q.out_item     <= 32'(best_tag_q);
			rsp_q.out_priority <= best_prio_q;
			rsp_q.out_order    <= best_order_q;
			rsp_q.occupancy    <= OCC_W'(occ_next);
		end
	end

endmodule

@@ src/deapq_chk.sv @@
`timescale 1ns / 1ps

module deapq_chk import deapq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAP_C);

	// An empty result can only come from a store that holds nothing.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0)
		else $error("empty status with nonzero occupancy");

	// An enqueue refused as full reports a full store.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.occupancy == CAP_OCC)
		else $error("full status without a full store");

	// A refused enqueue carries no entry.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_EXHAUSTED) |->
		rsp.out_item == '0 && rsp.out_order == '0 && rsp.out_priority == '0)
		else $error("refused enqueue returned entry data");

	// The block works on one transaction at a time.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while a transaction is in progress");

	// A stalled result holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

endmodule

bind double_ended_age_priority_queue deapq_chk #(.CAPACITY(CAPACITY)) u_deapq_chk (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench import deapq_pkg::*; ();

	localparam int CAP = 16;
	localparam int RANDOM_ITEMS = 800;
	// The last stretch of the random part runs with no idling on either side.
	localparam int QUIET_TAIL = 120;
	// Longest request is a full scan; this wait allows for it with margin on top.
	localparam int DRAIN_CYCLES = 4 * (CAP + 2);
	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [31:0] ORDER_LIMIT = 32'hFFFF_FFFF;

	// One transaction on the request side, with an optional typed-in result.
	// When typed is clear, the result comes from the queue model below.
	typedef struct {
		req_t r;
		bit   typed;
		rsp_t want;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	double_ended_age_priority_queue #(
		.CAPACITY(CAP),
		.TAG_BITS(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop. The slowest legal run is far below this.
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// Model of the store: tag, priority and order per slot, plus the valid
	// bits, the entry count and the order counter.
	logic [31:0]        model_tag [CAP];
	logic signed [31:0] model_prio [CAP];
	logic [31:0]        model_order [CAP];
	bit                 model_valid [CAP];
	logic [OCC_W-1:0]   model_count = '0;
	logic [31:0]        model_next = '0;

	stim_t directed[$];
	stim_t in_flight[$];
	rsp_t  pending_results[$];
	int    mismatch_count = 0;
	int    results_seen = 0;
	bit    idle_on = 1'b1;
	int    stall_left = 0;

	// True if slot a wins over slot b under the given selection mode.
	// Order numbers are unique, so a tie on priority always resolves by age.
	function automatic bit prefer(logic [1:0] mode, int a, int b);
		bit older;
		older = model_order[a] < model_order[b];
		case (mode)
		MODE_HIGH: begin
			return model_prio[a] > model_prio[b] || (model_prio[a] == model_prio[b] && older);
		end
		MODE_LOW: begin
			return model_prio[a] < model_prio[b] || (model_prio[a] == model_prio[b] && older);
		end
		MODE_OLDEST: begin
			return older;
		end
		default: begin
			return model_order[a] > model_order[b];
		end
		endcase
	endfunction

	// Apply one accepted request to the model and return the result it gives.
	function automatic rsp_t serve_request(req_t r);
		rsp_t res;
		int pick;
		int slot;
		res = '0;
		case (r.kind)
		KIND_ENQ: begin
			// A full store is refused before the order counter is looked at.
			if (model_count >= CAP) begin
				res.status = ST_FULL;
			end else if (model_next == ORDER_LIMIT) begin
				res.status = ST_EXHAUSTED;
			end else begin
				slot = 0;
				while (model_valid[slot])
					slot++;
				model_tag[slot] = r.item_tag;
				model_prio[slot] = r.priority_req;
				model_order[slot] = model_next;
				model_valid[slot] = 1'b1;
				model_count++;
				res.out_order = model_next;
				model_next++;
			end
		end
		KIND_PEEK, KIND_DEQ: begin
			pick = -1;
			for (int i = 0; i < CAP; i++) begin
				if (model_valid[i] && (pick < 0 || prefer(r.mode, i, pick)))
					pick = i;
			end
			if (pick < 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.out_item = model_tag[pick];
				res.out_priority = model_prio[pick];
				res.out_order = model_order[pick];
				if (r.kind == KIND_DEQ) begin
					model_valid[pick] = 1'b0;
					model_count--;
				end
			end
		end
		default: begin
			// The undefined kind leaves everything alone and reports ok.
			res.status = ST_OK;
		end
		endcase
		res.occupancy = model_count;
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
	endtask

	// Directed rows whose result is typed in.
	task automatic typed_row(logic [1:0] kind, logic [1:0] mode, logic [31:0] tag,
			logic [31:0] prio, logic [1:0] st, logic [31:0] item, logic [31:0] oprio,
			logic [31:0] order, int occ);
		stim_t s;
		s.r = '{kind: kind, mode: mode, item_tag: tag, priority_req: prio};
		s.typed = 1'b1;
		s.want = '{status: st, out_item: item, out_priority: oprio, out_order: order,
			occupancy: OCC_W'(occ)};
		directed = {directed, s};
	endtask

	// Directed rows checked against the model.
	task automatic plain_row(logic [1:0] kind, logic [1:0] mode, logic [31:0] tag,
			logic [31:0] prio);
		stim_t s;
		s.r = '{kind: kind, mode: mode, item_tag: tag, priority_req: prio};
		s.typed = 1'b0;
		s.want = '0;
		directed = {directed, s};
	endtask

	// Present one transaction, possibly after a short idle burst, and hold it
	// until the block takes it. The loop exits at the accepting edge.
	task automatic send_item(stim_t s);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_flight = {in_flight, s};
		req <= s.r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
	endtask

	// Receiver back-pressure: bursts of stalled cycles at random,
	// independent of whether a result is on offer.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 5);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Both channels are watched at the clock edge, where every input driven
	// by this bench and every output of the block still holds its old value.
	// Results are compared before the request of the same edge goes into the
	// model; a result can never belong to a request taken at that same edge.
	always @(posedge clk) begin : scoreboard
		stim_t s;
		rsp_t want;
		rsp_t predicted;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request waiting for it");
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(rsp.status), 32'(want.status));
					check_field("out_item", rsp.out_item, want.out_item);
					check_field("out_priority", rsp.out_priority, want.out_priority);
					check_field("out_order", rsp.out_order, want.out_order);
					check_field("occupancy", 32'(rsp.occupancy), 32'(want.occupancy));
				end
				results_seen++;
			end
			if (req_valid && !req_stall) begin
				// The model always runs so that its state tracks the block; a
				// typed-in result, where there is one, takes its place.
				s = in_flight.pop_front();
				predicted = serve_request(s.r);
				want = s.typed ? s.want : predicted;
				pending_results = {pending_results, want};
			end
		end
	end

	initial begin : stimulus
		stim_t s;
		int enq_pct;
		int roll;
		for (int i = 0; i < CAP; i++) begin
			model_valid[i] = 1'b0;
			model_tag[i] = '0;
			model_prio[i] = '0;
			model_order[i] = '0;
		end

		// Empty store: both peek and dequeue report empty with zero fields.
		typed_row(KIND_PEEK, MODE_HIGH, 32'h1234_5678, 32'h0, ST_EMPTY, 0, 0, 0, 0);
		typed_row(KIND_DEQ, MODE_NEWEST, 32'h0, 32'h0, ST_EMPTY, 0, 0, 0, 0);
		// Extremes of tag and priority, with a tie at each priority extreme.
		typed_row(KIND_ENQ, MODE_HIGH, 32'hFFFF_FFFF, 32'h7FFF_FFFF, ST_OK, 0, 0, 0, 1);
		typed_row(KIND_ENQ, MODE_LOW, 32'h0, 32'h8000_0000, ST_OK, 0, 0, 1, 2);
		typed_row(KIND_ENQ, MODE_OLDEST, 32'h2, 32'h7FFF_FFFF, ST_OK, 0, 0, 2, 3);
		typed_row(KIND_ENQ, MODE_NEWEST, 32'h3, 32'h8000_0000, ST_OK, 0, 0, 3, 4);
		// Ties on priority go to the older entry.
		typed_row(KIND_PEEK, MODE_HIGH, 32'h0, 32'h0, ST_OK, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			0, 4);
		typed_row(KIND_PEEK, MODE_LOW, 32'h0, 32'h0, ST_OK, 32'h0, 32'h8000_0000, 1, 4);
		typed_row(KIND_DEQ, MODE_OLDEST, 32'h0, 32'h0, ST_OK, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			0, 3);
		typed_row(KIND_DEQ, MODE_NEWEST, 32'h0, 32'h0, ST_OK, 32'h3, 32'h8000_0000, 3, 2);
		// Undefined kind: nothing changes.
		typed_row(KIND_NONE, MODE_NEWEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, ST_OK, 0, 0, 0, 2);
		// Fill the store, reusing the freed low slots first.
		plain_row(KIND_ENQ, MODE_HIGH, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
		plain_row(KIND_ENQ, MODE_LOW, 32'h5A5A_5A5A, 32'h0000_0001);
		plain_row(KIND_ENQ, MODE_OLDEST, 32'h8000_0000, 32'h0);
		plain_row(KIND_ENQ, MODE_NEWEST, 32'h0000_0001, 32'h0);
		plain_row(KIND_ENQ, MODE_HIGH, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
		plain_row(KIND_ENQ, MODE_HIGH, 32'hDEAD_0001, 32'h8000_0001);
		plain_row(KIND_ENQ, MODE_HIGH, 32'h0F0F_0F0F, 32'h7FFF_FFFF);
		plain_row(KIND_ENQ, MODE_HIGH, 32'hF0F0_F0F0, 32'h8000_0000);
		plain_row(KIND_ENQ, MODE_HIGH, 32'h0000_FFFF, 32'h0000_8000);
		plain_row(KIND_ENQ, MODE_HIGH, 32'hFFFF_0000, 32'hFFFF_8000);
		plain_row(KIND_ENQ, MODE_HIGH, 32'h3333_3333, 32'h0);
		plain_row(KIND_ENQ, MODE_HIGH, 32'hCCCC_CCCC, 32'h1234_5678);
		plain_row(KIND_ENQ, MODE_HIGH, 32'h5555_5555, 32'hEDCB_A988);
		plain_row(KIND_ENQ, MODE_HIGH, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
		// Full store refuses the enqueue.
		typed_row(KIND_ENQ, MODE_HIGH, 32'h1, 32'h1, ST_FULL, 0, 0, 0, 16);
		plain_row(KIND_DEQ, MODE_LOW, 32'h0, 32'h0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[k])
			send_item(directed[k]);

		// Random part. Each chunk of items leans toward enqueue or dequeue or is
		// balanced, so the occupancy swings between empty and full over and over.
		enq_pct = 50;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
				0: enq_pct = 25;
				1: enq_pct = 50;
				default: enq_pct = 80;
				endcase
			end
			// Idling is on most of the time, off for one stretch of 50 items in four, and off
			// for the whole tail of the run.
			idle_on <= (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 50) % 4 != 3);

			roll = $urandom_range(0, 99);
			if (roll < 3)
				s.r.kind = KIND_NONE;
			else if (roll < enq_pct)
				s.r.kind = KIND_ENQ;
			else if ($urandom_range(0, 9) < 6)
				s.r.kind = KIND_DEQ;
			else
				s.r.kind = KIND_PEEK;
			s.r.mode = 2'($urandom_range(0, 3));

			case ($urandom_range(0, 3))
			0: s.r.item_tag = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: s.r.item_tag = $urandom;
			endcase

			// Narrow priorities give plenty of ties; the extremes check the
			// signed compare at its ends.
			case ($urandom_range(0, 3))
			0: s.r.priority_req = 32'($urandom_range(0, 4)) - 32'd2;
			1: s.r.priority_req = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: s.r.priority_req = $urandom;
			endcase

			s.typed = 1'b0;
			s.want = '0;
			send_item(s);
		end
		req_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		// Every accepted request must have produced its result by now.
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
src/deapq_pkg.sv
src/deapq_ram.sv
src/deapq_cmp.sv
src/double_ended_age_priority_queue.sv
src/deapq_chk.sv
bench/testbench.sv
